// ===== rtl/axgrad_pkg.sv =====
// ----------------------------------------------------------------------------
// axgrad_pkg
// Shared types, constants and helper functions for the axisymmetric
// gradient block: state codes, accumulator indexes, item layout.
// ----------------------------------------------------------------------------
package axgrad_pkg;

   // default fraction bits of the Q format
   localparam int FRAC_BITS_DEF = 16;

   // accumulator count and index width
   localparam int N_ACC   = 6;
   localparam int ACC_IW  = 3;

   // accumulator indexes, also the order of the multiply steps
   localparam logic [ACC_IW-1:0] ACC_RR     = 3'd0;
   localparam logic [ACC_IW-1:0] ACC_RZ     = 3'd1;
   localparam logic [ACC_IW-1:0] ACC_ZR     = 3'd2;
   localparam logic [ACC_IW-1:0] ACC_ZZ     = 3'd3;
   localparam logic [ACC_IW-1:0] ACC_RADIAL = 3'd4;
   localparam logic [ACC_IW-1:0] ACC_RADIUS = 3'd5;
   // step after the last product: only the final add runs
   localparam logic [ACC_IW-1:0] STEP_FLUSH = 3'd6;

   // channel widths
   localparam int REQ_DATA_W = 192;
   localparam int RSP_DATA_W = 160;

   // saturation bounds
   localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
   localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] S32_MIN = 64'shFFFF_FFFF_8000_0000;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_FIN,
      ST_DIV,
      ST_EMIT
   } axg_state_type;

   // one node item as held during its multiply steps
   typedef struct packed {
      logic signed [31:0] shape_value;
      logic signed [31:0] dshape_r;
      logic signed [31:0] dshape_z;
      logic        [30:0] radius_coord;
      logic signed [31:0] vec_r;
      logic signed [31:0] vec_z;
   } axg_item_type;

   // sequencer controls toward the multiply-accumulate unit
   typedef struct packed {
      logic              mul_en;
      logic [ACC_IW-1:0] sel;
      logic              clear;
   } axg_mac_ctrl_type;

   // 64-bit add, saturating at the signed bounds
   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] && !s[63]) return S64_MIN;
      else if (!s[64] && s[63]) return S64_MAX;
      else return s[63:0];
   endfunction

   // clamp a 64-bit value to signed 32 bits
   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      logic signed [63:0] c;
      if (v > S32_MAX) c = S32_MAX;
      else if (v < S32_MIN) c = S32_MIN;
      else c = v;
      return c[31:0];
   endfunction

endpackage

// ===== rtl/axisym_gradient_at_point.sv =====
// ----------------------------------------------------------------------------
// axisym_gradient_at_point
// Axisymmetric deformation or velocity gradient at one integration point.
// ----------------------------------------------------------------------------
// Usage: each req item carries one node of an element (shape value, its r and
// z derivatives, node radius, nodal vector); req_tlast marks the element's
// last node. The block sums the 2x2 in-plane gradient, the interpolated
// radius and the radial component, and on the last node sends one rsp item
// holding g_rr, g_rz, g_zr, g_zz and the hoop term, with rsp_tuser set when
// the interpolated radius was zero (hoop term saturated then).
// csr_wr_en writes the mode bit: 0 adds the identity, 1 starts from zero.
// A node passes through an accept step, six products through one shared
// multiplier and accumulate stage, and one flush. The last node adds the
// result reads, the restoring divider (one quotient bit a cycle) and the load
// of the output register before rsp_tvalid. req_tready is high only while idle.
// A stalled receiver holds the result in the output register; the next
// element is accepted and summed meanwhile, and waits only to be emitted.
// Reset clears the accumulators, the mode bit and both valid flags.
// ----------------------------------------------------------------------------
module axisym_gradient_at_point
   import axgrad_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // input items
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // shape_value[31:0], dshape_r[63:32], dshape_z[95:64], radius_coord[126:96],
   // vec_r[158:127], vec_z[190:159], zero[191]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   // result items
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // g_rr[31:0], g_rz[63:32], g_zr[95:64], g_zz[127:96], g_hoop[159:128]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // radius_zero[0]
   output logic                  rsp_tuser,
   // configuration
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data
);

   axg_state_type    state_ff, state_in;
   logic [2:0]       cnt_ff, cnt_in;
   axg_item_type     item_ff;
   logic             last_ff;
   logic             mode_ff;
   axg_mac_ctrl_type mac_ctrl;

   logic signed [63:0] rd_data;
   logic signed [63:0] acc_radial;
   logic signed [63:0] acc_radius;
   logic               div_start;
   logic               div_done;
   logic [33:0]        div_mag;

   logic signed [63:0] one_val;
   logic signed [63:0] plane_val;
   logic signed [63:0] mag_ext;
   logic signed [63:0] hoop_val;
   logic [31:0]        hoop_res;

   logic [31:0] w_g_ff [4];
   logic [31:0] w_hoop_ff;
   logic        w_rz_ff;
   logic        rz_ff;
   logic        radial_neg_ff;
   logic        quo_neg_ff;

   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_user_ff;
   logic                  rsp_valid_ff;

   logic req_acc;
   logic out_load;
   logic fin_write;

   assign req_acc = req_tvalid && req_tready;

   // mode register
   always_ff @(posedge clock) begin
      if (reset) mode_ff <= 1'b0;
      else if (csr_wr_en) mode_ff <= csr_wr_data;
   end

   // node item capture
   always_ff @(posedge clock) begin
      if (req_acc) begin
         item_ff.shape_value  <= req_tdata[31:0];
         item_ff.dshape_r     <= req_tdata[63:32];
         item_ff.dshape_z     <= req_tdata[95:64];
         item_ff.radius_coord <= req_tdata[126:96];
         item_ff.vec_r        <= req_tdata[158:127];
         item_ff.vec_z        <= req_tdata[190:159];
         last_ff              <= req_tlast;
      end
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state and controls
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      req_tready   = 1'b0;
      mac_ctrl     = '0;
      div_start    = 1'b0;
      out_load     = 1'b0;
      fin_write    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cnt_in   = '0;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            mac_ctrl.sel    = cnt_ff;
            mac_ctrl.mul_en = (cnt_ff != STEP_FLUSH);
            if (cnt_ff == STEP_FLUSH) begin
               cnt_in   = '0;
               state_in = last_ff ? ST_FIN : ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FIN: begin
            mac_ctrl.sel = cnt_ff;
            fin_write    = 1'b1;
            if (cnt_ff == ACC_ZZ) begin
               div_start      = 1'b1;
               mac_ctrl.clear = 1'b1;
               state_in       = ST_DIV;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DIV: begin
            if (div_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // shared multiply-accumulate unit
   axgrad_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .item       (item_ff),
      .ctrl       (mac_ctrl),
      .rd_data    (rd_data),
      .acc_radial (acc_radial),
      .acc_radius (acc_radius)
   );

   // hoop divider
   axgrad_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (acc_radial),
      .den   (acc_radius),
      .done  (div_done),
      .mag   (div_mag)
   );

   // identity term, read when the result is formed
   assign one_val = mode_ff ? 64'sd0 : (64'sd1 <<< FRAC_BITS);

   // in-plane term: floor shift, identity on the diagonal
   always_comb begin
      plane_val = rd_data >>> FRAC_BITS;
      if (mac_ctrl.sel == ACC_RR || mac_ctrl.sel == ACC_ZZ) plane_val = plane_val + one_val;
   end

   always_ff @(posedge clock) begin
      if (fin_write) w_g_ff[cnt_ff[1:0]] <= sat32(plane_val);
   end

   // sign and zero-radius capture at divider start
   always_ff @(posedge clock) begin
      if (div_start) begin
         rz_ff         <= (acc_radius == 64'sd0);
         radial_neg_ff <= acc_radial[63];
         quo_neg_ff    <= acc_radial[63] ^ acc_radius[63];
      end
   end

   // hoop term: signed quotient plus identity, or the zero-radius limit
   assign mag_ext  = $signed({30'd0, div_mag});
   assign hoop_val = (quo_neg_ff ? -mag_ext : mag_ext) + one_val;
   always_comb begin
      if (rz_ff) hoop_res = radial_neg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
      else hoop_res = sat32(hoop_val);
   end

   always_ff @(posedge clock) begin
      if (div_done) begin
         w_hoop_ff <= hoop_res;
         w_rz_ff   <= rz_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= {w_hoop_ff, w_g_ff[3], w_g_ff[2], w_g_ff[1], w_g_ff[0]};
         rsp_user_ff <= w_rz_ff;
      end
      if (reset) rsp_valid_ff <= 1'b0;
      else if (out_load) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   // zero-radius flag comes with a saturated hoop term
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         (rsp_tdata[159:128] == 32'h7FFF_FFFF || rsp_tdata[159:128] == 32'h8000_0000))
      else $error("radius_zero set without saturated hoop term");

   // accumulators are clear once the divider has taken its operands
   assert property (@(posedge clock) disable iff (reset)
      div_start |=> (acc_radial == 64'sd0 && acc_radius == 64'sd0))
      else $error("accumulators not cleared after result pass");

   // divider finishes only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider done outside wait state");

   // an item is taken only while no node is in flight
   assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff == ST_MAC && cnt_ff == 3'd0)
      else $error("accepted item did not start multiply steps");
`endif

endmodule

// ===== rtl/axgrad_mac.sv =====
// ----------------------------------------------------------------------------
// axgrad_mac
// Shared 32x32 signed multiplier with a product register, followed by a
// saturating 64-bit add into one of six accumulators, one product a cycle.
// ----------------------------------------------------------------------------
module axgrad_mac
   import axgrad_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  axg_item_type       item,
   input  axg_mac_ctrl_type   ctrl,
   output logic signed [63:0] rd_data,
   output logic signed [63:0] acc_radial,
   output logic signed [63:0] acc_radius
);

   logic signed [31:0] op_a;
   logic signed [31:0] op_b;
   logic signed [63:0] prod_in;
   logic signed [63:0] prod_ff;
   logic               pvalid_ff;
   logic [ACC_IW-1:0]  psel_ff;
   logic signed [63:0] acc_ff [N_ACC];

   // operand selection per step
   always_comb begin
      unique case (ctrl.sel)
         ACC_RR: begin
            op_a = item.dshape_r;
            op_b = item.vec_r;
         end
         ACC_RZ: begin
            op_a = item.dshape_z;
            op_b = item.vec_r;
         end
         ACC_ZR: begin
            op_a = item.dshape_r;
            op_b = item.vec_z;
         end
         ACC_ZZ: begin
            op_a = item.dshape_z;
            op_b = item.vec_z;
         end
         ACC_RADIAL: begin
            op_a = item.shape_value;
            op_b = item.vec_r;
         end
         ACC_RADIUS: begin
            op_a = item.shape_value;
            op_b = $signed({1'b0, item.radius_coord});
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign prod_in = op_a * op_b;

   // product register and its tag
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         pvalid_ff <= 1'b0;
         psel_ff   <= '0;
      end else begin
         pvalid_ff <= ctrl.mul_en;
         psel_ff   <= ctrl.sel;
      end
   end

   // saturating accumulate, cleared after each element
   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         for (int i = 0; i < N_ACC; i++) acc_ff[i] <= '0;
      end else if (pvalid_ff) begin
         acc_ff[psel_ff] <= sat_add64(acc_ff[psel_ff], prod_ff);
      end
   end

   // read port for the result pass
   always_comb begin
      unique case (ctrl.sel)
         ACC_RR:     rd_data = acc_ff[ACC_RR];
         ACC_RZ:     rd_data = acc_ff[ACC_RZ];
         ACC_ZR:     rd_data = acc_ff[ACC_ZR];
         ACC_ZZ:     rd_data = acc_ff[ACC_ZZ];
         ACC_RADIAL: rd_data = acc_ff[ACC_RADIAL];
         ACC_RADIUS: rd_data = acc_ff[ACC_RADIUS];
         default:    rd_data = '0;
      endcase
   end

   assign acc_radial = acc_ff[ACC_RADIAL];
   assign acc_radius = acc_ff[ACC_RADIUS];

endmodule

// ===== rtl/axgrad_div.sv =====
// ----------------------------------------------------------------------------
// axgrad_div
// Restoring divider for the hoop term: |num| * 2^FRAC_BITS / |den|,
// truncated, one quotient bit a cycle; quotients of 2^33 and up are capped.
// ----------------------------------------------------------------------------
module axgrad_div
   import axgrad_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] num,
   input  logic signed [63:0] den,
   output logic               done,
   output logic [33:0]        mag
);

   localparam int QBITS    = 33;
   localparam int HI_SHIFT = QBITS - FRAC_BITS;
   localparam int CNT_W    = $clog2(QBITS + 1);

   logic [63:0]            num_mag;
   logic [63:0]            den_mag;
   logic [63+FRAC_BITS:0]  num_scaled;
   logic [63:0]            num_hi;
   logic [64:0]            trial;
   logic                   take;

   logic [63:0]      den_ff;
   logic [63:0]      rem_ff;
   logic [QBITS-1:0] low_ff;
   logic [QBITS-1:0] quo_ff;
   logic             ovf_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   // magnitudes and the numerator split into head and bits to bring down
   assign num_mag    = num[63] ? 64'(-num) : 64'(num);
   assign den_mag    = den[63] ? 64'(-den) : 64'(den);
   assign num_scaled = {num_mag, FRAC_BITS'(0)};
   assign num_hi     = num_mag >> HI_SHIFT;

   // one restoring step
   assign trial = {rem_ff, low_ff[QBITS-1]};
   assign take  = trial >= {1'b0, den_ff};

   // datapath registers
   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= den_mag;
         rem_ff <= num_hi;
         low_ff <= num_scaled[QBITS-1:0];
         quo_ff <= '0;
         ovf_ff <= num_hi >= den_mag;
      end else if (busy_ff) begin
         rem_ff <= take ? 64'(trial - {1'b0, den_ff}) : trial[63:0];
         low_ff <= {low_ff[QBITS-2:0], 1'b0};
         quo_ff <= {quo_ff[QBITS-2:0], take};
      end
   end

   // iteration control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(QBITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign mag  = ovf_ff ? (34'd1 << QBITS) : {1'b0, quo_ff};

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for axisym_gradient_at_point. Node items are streamed
// in, directed corner cases first, then random elements under changing
// flow control. A scoreboard keeps its own copy of the six sums and the mode
// bit, forms the expected gradient and hoop terms on each last node, and
// compares them field by field with what comes out of the block.
// ----------------------------------------------------------------------------
module tb;
   import axgrad_pkg::*;

   localparam int FRAC          = FRAC_BITS_DEF;
   localparam int SETTLE_CYCLES = 64;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SEGMENT_ITEMS = 150;

   localparam logic [31:0] Q_ONE  = 32'h0001_0000;
   localparam logic [31:0] Q_HALF = 32'h0000_8000;
   localparam logic [31:0] Q_NHALF = 32'hFFFF_8000;

   // value styles for random fields
   typedef enum {Q_FULL, Q_UNIT, Q_SMALL, Q_EDGE} q_style_e;

   typedef struct packed {
      logic [31:0] g_rr;
      logic [31:0] g_rz;
      logic [31:0] g_zr;
      logic [31:0] g_zz;
      logic [31:0] g_hoop;
      logic        radius_zero;
   } gradient_result_t;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_wr_en;
   logic                  csr_wr_data;

   int req_idle_pct;
   int rsp_idle_pct;
   int cycle_count;

   // ------------------------------------------------------------------------
   // gradient scoreboard: running sums, mode bit and pending results
   // ------------------------------------------------------------------------
   class gradient_scoreboard;
      bit                 mode;
      logic signed [63:0] sum_rr, sum_rz, sum_zr, sum_zz, sum_radial, sum_radius;
      gradient_result_t   expected_q[$];
      int                 errors;

      function new();
         mode   = 1'b0;
         errors = 0;
         clear_sums();
      endfunction

      function void clear_sums();
         sum_rr = '0;
         sum_rz = '0;
         sum_zr = '0;
         sum_zz = '0;
         sum_radial = '0;
         sum_radius = '0;
      endfunction

      function void set_mode(bit m);
         mode = m;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // add with clamping at the signed 64-bit bounds
      function logic signed [63:0] clamp_add(logic signed [63:0] a, logic signed [63:0] b);
         logic signed [64:0] s;
         s = a + b;
         if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
         return s[63:0];
      endfunction

      function logic [31:0] clamp32(logic signed [63:0] v);
         if (v > S32_MAX) return 32'h7FFF_FFFF;
         if (v < S32_MIN) return 32'h8000_0000;
         return v[31:0];
      endfunction

      // radial over radius in Q form, truncated, magnitude capped at 2^33
      function logic signed [63:0] hoop_quotient(logic signed [63:0] num,
                                                 logic signed [63:0] den);
         logic [63:0]  n_mag, d_mag, whole, mag;
         logic [127:0] scaled;
         n_mag = num[63] ? (64'd0 - num) : num;
         d_mag = den[63] ? (64'd0 - den) : den;
         whole = n_mag / d_mag;
         if (whole >= (64'd1 << (33 - FRAC))) begin
            mag = 64'd1 << 33;
         end else begin
            scaled = {64'd0, n_mag} << FRAC;
            scaled = scaled / {64'd0, d_mag};
            mag = scaled[63:0];
         end
         return (num[63] != den[63]) ? -$signed(mag) : $signed(mag);
      endfunction

      // accepted node: update sums, form a result on the last node
      function void note_node(axg_item_type it, bit last);
         logic signed [63:0] n64, dr64, dz64, rc64, vr64, vz64, one;
         gradient_result_t   r;
         n64  = it.shape_value;
         dr64 = it.dshape_r;
         dz64 = it.dshape_z;
         rc64 = $signed({33'd0, it.radius_coord});
         vr64 = it.vec_r;
         vz64 = it.vec_z;
         sum_rr     = clamp_add(sum_rr, dr64 * vr64);
         sum_rz     = clamp_add(sum_rz, dz64 * vr64);
         sum_zr     = clamp_add(sum_zr, dr64 * vz64);
         sum_zz     = clamp_add(sum_zz, dz64 * vz64);
         sum_radial = clamp_add(sum_radial, n64 * vr64);
         sum_radius = clamp_add(sum_radius, n64 * rc64);
         if (!last) return;
         one = mode ? 64'sd0 : (64'sd1 <<< FRAC);
         r.g_rr = clamp32((sum_rr >>> FRAC) + one);
         r.g_rz = clamp32(sum_rz >>> FRAC);
         r.g_zr = clamp32(sum_zr >>> FRAC);
         r.g_zz = clamp32((sum_zz >>> FRAC) + one);
         if (sum_radius == 0) begin
            r.radius_zero = 1'b1;
            r.g_hoop = (sum_radial < 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end else begin
            r.radius_zero = 1'b0;
            r.g_hoop = clamp32(hoop_quotient(sum_radial, sum_radius) + one);
         end
         expected_q.push_back(r);
         clear_sums();
      endfunction

      // compare one result item with the oldest expectation
      function void check_result(logic [RSP_DATA_W-1:0] data, logic zero_flag);
         gradient_result_t want;
         logic [31:0]      want_f[5];
         string            names[5];
         int               i;
         names = '{"g_rr", "g_rz", "g_zr", "g_zz", "g_hoop"};
         if (expected_q.size() == 0) begin
            $display("%0t: result with nothing expected, data %h", $time, data);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         want_f = '{want.g_rr, want.g_rz, want.g_zr, want.g_zz, want.g_hoop};
         for (i = 0; i < 5; i++) begin
            if (data[32*i +: 32] !== want_f[i]) begin
               $display("%0t: %s expected %h actual %h", $time, names[i], want_f[i],
                        data[32*i +: 32]);
               errors++;
            end
         end
         if (zero_flag !== want.radius_zero) begin
            $display("%0t: radius_zero expected %b actual %b", $time, want.radius_zero,
                     zero_flag);
            errors++;
         end
      endfunction

      function void report_missing();
         if (expected_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_q.size());
            errors += expected_q.size();
         end
      endfunction
   endclass

   gradient_scoreboard sb;

   axisym_gradient_at_point i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      if (!reset) rsp_tready = ($urandom_range(99) >= rsp_idle_pct);
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
   end

   function automatic axg_item_type mk_node(logic [31:0] n, logic [31:0] dr,
                                            logic [31:0] dz, logic [30:0] rc,
                                            logic [31:0] vr, logic [31:0] vz);
      axg_item_type it;
      it.shape_value  = n;
      it.dshape_r     = dr;
      it.dshape_z     = dz;
      it.radius_coord = rc;
      it.vec_r        = vr;
      it.vec_z        = vz;
      return it;
   endfunction

   function automatic logic [31:0] rand_q(q_style_e s);
      case (s)
         Q_UNIT:  return $urandom_range(0, 32'h0001_0000);
         Q_SMALL: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
         Q_EDGE: begin
            case ($urandom_range(4))
               0:       return 32'h8000_0000;
               1:       return 32'h7FFF_FFFF;
               2:       return 32'h0000_0000;
               3:       return 32'hFFFF_FFFF;
               default: return 32'h0000_0001;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [30:0] rand_radius(q_style_e s);
      logic [31:0] v;
      case (s)
         Q_UNIT:  v = $urandom_range(0, 100 << FRAC);
         Q_SMALL: v = $urandom_range(0, 2 << FRAC);
         Q_EDGE: begin
            case ($urandom_range(2))
               0:       v = 32'h0000_0000;
               1:       v = 32'h0000_0001;
               default: v = 32'h7FFF_FFFF;
            endcase
         end
         default: v = $urandom;
      endcase
      return v[30:0];
   endfunction

   // present one node and hold it until accepted
   task automatic send_node(input axg_item_type it, input bit last);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {1'b0, it.vec_z, it.vec_r, it.radius_coord, it.dshape_z, it.dshape_r,
                    it.shape_value};
      req_tlast  = last;
      do @(posedge clock); while (!req_tready);
      sb.note_node(it, last);
   endtask

   // let every expected result arrive and the block go idle
   task automatic settle_block();
      @(negedge clock);
      req_tvalid = 1'b0;
      req_tlast  = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input bit m);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = m;
      @(posedge clock);
      sb.set_mode(m);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // random elements until the item count reaches the quota
   task automatic run_segment(input int quota);
      int           sent, kind, len, i;
      bit           broken;
      q_style_e     s_sh, s_d, s_rc, s_v;
      axg_item_type it, prev;
      sent = 0;
      while (sent < quota) begin
         kind   = $urandom_range(99);
         len    = ($urandom_range(3) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
         broken = ($urandom_range(99) < 5);
         s_sh = Q_UNIT;
         s_d  = Q_SMALL;
         s_rc = Q_UNIT;
         s_v  = Q_SMALL;
         if (kind >= 55 && kind < 70) begin
            s_sh = Q_FULL; s_d = Q_FULL; s_rc = Q_FULL; s_v = Q_FULL;
         end else if (kind >= 80 && kind < 88) begin
            s_sh = Q_SMALL;
         end else if (kind >= 88 && kind < 92) begin
            len = 2 * $urandom_range(1, 3);
         end else if (kind >= 92) begin
            s_sh = Q_EDGE; s_d = Q_EDGE; s_rc = Q_EDGE; s_v = Q_EDGE;
         end
         for (i = 0; i < len; i++) begin
            it = mk_node(rand_q(s_sh), rand_q(s_d), rand_q(s_d), rand_radius(s_rc),
                         rand_q(s_v), rand_q(s_v));
            // element sitting on the axis
            if (kind >= 70 && kind < 80) it.radius_coord = '0;
            // pairs that cancel the interpolated radius exactly
            if (kind >= 88 && kind < 92 && i[0]) begin
               it.shape_value  = -prev.shape_value;
               it.radius_coord = prev.radius_coord;
            end
            prev = it;
            send_node(it, !broken && (i == len - 1));
         end
         sent += len;
      end
   endtask

   // main sequence
   initial begin
      int seg;
      sb = new();
      cycle_count  = 0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tlast    = 1'b0;
      rsp_tready   = 1'b0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = 1'b0;
      req_idle_pct = 33;
      rsp_idle_pct = 80;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: deformation gradient
      write_mode(1'b0);
      // plain four-node element
      send_node(mk_node(32'h4000, Q_NHALF, Q_NHALF, 31'h1_0000, 32'h0800, 32'hFFFF_F000), 0);
      send_node(mk_node(32'h4000, Q_HALF,  Q_NHALF, 31'h2_0000, 32'h1000, 32'h0400), 0);
      send_node(mk_node(32'h4000, Q_HALF,  Q_HALF,  31'h2_0000, 32'hFFFF_E000, 32'h0200), 0);
      send_node(mk_node(32'h4000, Q_NHALF, Q_HALF,  31'h1_0000, 32'h0100, 32'h0), 1);
      // all zero: radius zero with non-negative radial
      send_node(mk_node(32'h0, 32'h0, 32'h0, 31'h0, 32'h0, 32'h0), 1);
      // radius zero with negative radial
      send_node(mk_node(Q_ONE, Q_ONE, Q_ONE, 31'h0, 32'hFFFF_0000, Q_ONE), 1);
      // sums driven to their positive and negative bounds
      repeat (2) send_node(mk_node(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                   31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF), 0);
      send_node(mk_node(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                        32'h8000_0000, 32'h7FFF_FFFF), 1);
      // extreme values over two nodes: the rz sum saturates, the others come near the bounds
      send_node(mk_node(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF,
                        32'h8000_0000, 32'h7FFF_FFFF), 0);
      send_node(mk_node(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF,
                        32'h8000_0000, 32'h7FFF_FFFF), 1);
      // negative interpolated radius divides with its sign
      send_node(mk_node(32'hFFFF_0000, Q_ONE, Q_ONE, 31'h2_0000, 32'h3_0000, Q_ONE), 1);
      // tiny radius, quotient capped
      send_node(mk_node(32'h1, Q_ONE, Q_ONE, 31'h1, 32'h7FFF_FFFF, 32'h0), 1);
      // mode changed while an element is half summed
      send_node(mk_node(Q_HALF, Q_ONE, Q_NHALF, 31'h3_0000, 32'h2_0000, 32'hFFFF_0000), 0);
      send_node(mk_node(Q_HALF, Q_NHALF, Q_ONE, 31'h1_0000, 32'hFFFF_8000, 32'h0001_8000), 0);
      settle_block();
      write_mode(1'b1);
      send_node(mk_node(32'h0, Q_ONE, Q_ONE, 31'h1_0000, Q_ONE, Q_ONE), 1);
      // velocity gradient elements
      send_node(mk_node(Q_HALF, Q_ONE, Q_NHALF, 31'h4_0000, 32'h0002_0000, 32'h0), 0);
      send_node(mk_node(Q_HALF, Q_NHALF, Q_ONE, 31'h6_0000, 32'hFFFF_C000, 32'h4000), 1);
      send_node(mk_node(32'h0, Q_ONE, Q_ONE, 31'h5_0000, 32'h0, Q_ONE), 1);
      // every field bit set
      send_node(mk_node(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF), 1);
      settle_block();

      // random: two segments per flow-control profile, mode alternating
      for (seg = 0; seg < 6; seg++) begin
         req_idle_pct = (seg < 2) ? 33 : (seg < 4) ? 80 : 0;
         rsp_idle_pct = (seg < 2) ? 80 : (seg < 4) ? 33 : 0;
         write_mode(seg[0]);
         run_segment(SEGMENT_ITEMS);
         settle_block();
      end

      sb.report_missing();
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/axgrad_pkg.sv
rtl/axgrad_mac.sv
rtl/axgrad_div.sv
rtl/axisym_gradient_at_point.sv
verif/tb.sv
